// File: rtl/two_channel_daylight_ramp_sequencer_assert.svh
// Assertion macros shared by the daylight ramp sequencer RTL.
`ifndef TWO_CHANNEL_DAYLIGHT_RAMP_SEQUENCER_ASSERT_SVH
`define TWO_CHANNEL_DAYLIGHT_RAMP_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/drs_pkg.sv
// Shared types, constants and helpers for the daylight ramp sequencer.
`default_nettype none

package drs_pkg;

    localparam int unsigned DUR_BITS       = 26;
    localparam int unsigned PEAK_BITS      = 8;
    localparam int unsigned ADV_BITS       = 10;
    localparam int unsigned OUT_LVL_BITS   = 8;
    localparam int unsigned CFG_IDX_BITS   = 3;
    localparam int unsigned NPHASE         = 6;

    localparam int unsigned LEVEL_MAX_DEF  = 255;
    localparam int unsigned TIME_BITS_DEF  = 26;

    localparam int unsigned RELAY_ON_LEVEL = 5;
    localparam int unsigned DUSK_OFF_LEVEL = 50;

    localparam int unsigned DUR_RESET      = 5000;
    localparam int unsigned PEAK_RESET     = 191;

    typedef enum logic [2:0] {
        PH_DAWN    = 3'd0,
        PH_SUNRISE = 3'd1,
        PH_NOON    = 3'd2,
        PH_SUNSET  = 3'd3,
        PH_DUSK    = 3'd4,
        PH_NIGHT   = 3'd5
    } t_phase;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_DAWN_MS    = 3'd0,
        CFG_SUNRISE_MS = 3'd1,
        CFG_NOON_MS    = 3'd2,
        CFG_SUNSET_MS  = 3'd3,
        CFG_DUSK_MS    = 3'd4,
        CFG_NIGHT_MS   = 3'd5,
        CFG_BLUE_PEAK  = 3'd6
    } t_cfg_reg;

    typedef struct packed {
        logic [ADV_BITS-1:0] advance_ms;
        logic                restart;
    } t_tick;

    typedef struct packed {
        logic [2:0]              phase;
        logic [OUT_LVL_BITS-1:0] blue_level;
        logic [OUT_LVL_BITS-1:0] white_level;
        logic [OUT_LVL_BITS-1:0] blue_drive;
        logic [OUT_LVL_BITS-1:0] white_drive;
        logic                    blue_relay_on;
        logic                    white_relay_on;
    } t_result;

    typedef struct packed {
        logic                    valid;
        logic [CFG_IDX_BITS-1:0] index;
        logic [DUR_BITS-1:0]     data;
    } t_cfg_write;

    // Phase that follows p in the day cycle; night wraps round to dawn.
    function automatic t_phase phase_next(input t_phase p);
        t_phase r;
        unique case (p)
            PH_DAWN:    r = PH_SUNRISE;
            PH_SUNRISE: r = PH_NOON;
            PH_NOON:    r = PH_SUNSET;
            PH_SUNSET:  r = PH_DUSK;
            PH_DUSK:    r = PH_NIGHT;
            default:    r = PH_DAWN;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/drs_ramp_div.sv
// Bit-serial scaled divider: quotient of elapsed times span over duration.
`default_nettype none

module drs_ramp_div
    import drs_pkg::*;
#(
    parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
    parameter int unsigned LEVEL_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [TIME_BITS-1:0]  i_elapsed,
    input  wire logic [LEVEL_BITS-1:0] i_span,
    input  wire logic [TIME_BITS-1:0]  i_dur,
    output logic                       o_busy,
    output logic                       o_done,
    output logic [LEVEL_BITS-1:0]      o_quot
);

    localparam int unsigned CNT_W = $clog2(LEVEL_BITS + 1);
    localparam int unsigned PW    = TIME_BITS + 2;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [TIME_BITS-1:0]  r_e;
    logic [TIME_BITS-1:0]  r_d;
    logic [TIME_BITS-1:0]  r_rem;
    logic [LEVEL_BITS-1:0] r_m;
    logic [LEVEL_BITS-1:0] r_q;

    logic [PW-1:0]         part;
    logic [PW-1:0]         d1;
    logic [PW-1:0]         d2;
    logic [1:0]            digit;
    logic [PW-1:0]         n_part;
    logic [TIME_BITS-1:0]  n_rem;
    logic [LEVEL_BITS-1:0] n_q;

    // One multiplier bit per cycle: the partial remainder stays below three
    // times the divisor, so each step yields a quotient digit of 0, 1 or 2.
    always_comb begin
        part = {r_rem, 1'b0} + (r_m[LEVEL_BITS-1] ? PW'(r_e) : '0);
        d1   = PW'(r_d);
        d2   = PW'({r_d, 1'b0});
        if (part >= d2) begin
            digit  = 2'd2;
            n_part = part - d2;
        end else if (part >= d1) begin
            digit  = 2'd1;
            n_part = part - d1;
        end else begin
            digit  = 2'd0;
            n_part = part;
        end
        n_rem = n_part[TIME_BITS-1:0];
        n_q   = {r_q[LEVEL_BITS-2:0], 1'b0} + LEVEL_BITS'(digit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(LEVEL_BITS);
                r_rem  <= '0;
                r_q    <= '0;
                r_e    <= i_elapsed;
                r_d    <= i_dur;
                r_m    <= i_span;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= n_q;
                r_m   <= {r_m[LEVEL_BITS-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: rtl/drs_cfg_regs.sv
// Configuration registers with clamped duration lookup and clamped peak.
`default_nettype none

module drs_cfg_regs
    import drs_pkg::*;
#(
    parameter int unsigned LEVEL_MAX  = LEVEL_MAX_DEF,
    parameter int unsigned TIME_BITS  = TIME_BITS_DEF,
    parameter int unsigned LEVEL_BITS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg_write            i_wr,
    input  wire t_phase                i_phase,
    output logic [TIME_BITS-1:0]       o_dur,
    output logic [LEVEL_BITS-1:0]      o_peak
);

    localparam int unsigned CW = (TIME_BITS > DUR_BITS) ? TIME_BITS : DUR_BITS;
    localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIME_BITS) - 64'd1);

    logic [DUR_BITS-1:0]  r_dur [NPHASE];
    logic [PEAK_BITS-1:0] r_peak;
    logic [CW-1:0]        raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NPHASE; i++) begin
                r_dur[i] <= DUR_BITS'(DUR_RESET);
            end
            r_peak <= PEAK_BITS'(PEAK_RESET);
        end else if (i_wr.valid) begin
            unique case (i_wr.index)
                CFG_DAWN_MS, CFG_SUNRISE_MS, CFG_NOON_MS,
                CFG_SUNSET_MS, CFG_DUSK_MS, CFG_NIGHT_MS: begin
                    r_dur[i_wr.index] <= i_wr.data;
                end
                CFG_BLUE_PEAK: begin
                    r_peak <= i_wr.data[PEAK_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Durations beyond the elapsed counter's range are held at its maximum.
    always_comb begin
        raw   = CW'(r_dur[i_phase]);
        o_dur = (raw > TMAX) ? TMAX[TIME_BITS-1:0] : raw[TIME_BITS-1:0];
        if (32'(r_peak) > 32'(LEVEL_MAX)) begin
            o_peak = LEVEL_BITS'(LEVEL_MAX);
        end else begin
            o_peak = LEVEL_BITS'(r_peak);
        end
    end

endmodule

`default_nettype wire

// File: rtl/two_channel_daylight_ramp_sequencer.sv
// Top level of the two-channel daylight ramp sequencer.
`default_nettype none

// Two-channel daylight ramp sequencer. Every tick transfer carries the
// milliseconds since the previous tick, or a restart, and produces exactly
// one result transfer with the phase, the blue and white levels, their
// active-low PWM compare values (full scale minus level) and the two supply
// relay states. The day runs dawn, sunrise, noon, sunset, dusk and night
// and then repeats; a phase with zero duration is skipped, and a phase ends
// on the tick after its elapsed time reached its duration. Ramp levels are
// start + elapsed*(end-start)/duration, truncated towards zero. Each level
// is worked out by a bit-serial divider that takes one level bit per cycle,
// and blue and white share it one after the other. A tick runs the phase
// search when the current phase has ended, then the time advance and the
// blue and white divisions; levels are as wide as LEVEL_MAX needs. A
// restart also runs the phase search but skips the time advance. The tick
// channel accepts the next transfer as soon as the block has handed its
// result to the output register, even if that result has not yet been
// taken downstream. Configuration writes are always accepted and should
// only be issued while no tick is in progress.
module two_channel_daylight_ramp_sequencer
    import drs_pkg::*;
#(
    parameter int unsigned LEVEL_MAX = LEVEL_MAX_DEF,
    parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_tick_valid,
    output logic                         o_tick_ready,
    input  wire t_tick                   i_tick,
    output logic                         o_res_valid,
    input  wire logic                    i_res_ready,
    output t_result                      o_res,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [DUR_BITS-1:0]     i_cfg_data
);

    localparam int unsigned LB  = $clog2(LEVEL_MAX + 1);
    localparam int unsigned TW1 = TIME_BITS + 1;
    localparam logic [LB-1:0] LVL_FULL = LB'(LEVEL_MAX);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ADV,
        S_BLUE_GO,
        S_BLUE_WAIT,
        S_WHITE_GO,
        S_WHITE_WAIT,
        S_DONE
    } t_state;

    t_state               r_state;
    t_phase               r_phase;
    t_phase               r_scan;
    logic [2:0]           r_tries;
    logic [TIME_BITS-1:0] r_elapsed;
    logic [ADV_BITS-1:0]  r_adv;
    logic                 r_restart;
    logic                 r_blue_sw;
    logic                 r_white_sw;
    logic [LB-1:0]        r_blue;
    logic [LB-1:0]        r_white;
    t_result              r_out;
    logic                 r_out_valid;

    t_cfg_write           cfg_wr;
    t_phase               lut_phase;
    t_phase               scan_next;
    logic [TIME_BITS-1:0] dur;
    logic [LB-1:0]        peak;
    logic                 dur_zero;

    logic                 white_sel;
    logic [LB-1:0]        ramp_a;
    logic [LB-1:0]        ramp_b;
    logic                 ramp_up;
    logic [LB-1:0]        span;
    logic [TIME_BITS-1:0] e_clamped;
    logic [LB-1:0]        level_new;

    logic                 div_start;
    logic                 div_busy;
    logic                 div_done;
    logic [LB-1:0]        div_quot;

    logic [TW1-1:0]       adv_sum;
    logic                 n_blue_sw;
    logic                 n_white_sw;
    logic                 tick_take;

    assign cfg_wr.valid = i_cfg_valid;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;
    assign o_cfg_ready  = 1'b1;

    // The duration lookup has a single read port: during the phase search it
    // looks at the candidate phase, otherwise at the current phase.
    assign scan_next = phase_next(r_scan);
    assign lut_phase = (r_state == S_SCAN) ? scan_next : r_phase;

    drs_cfg_regs #(
        .LEVEL_MAX  (LEVEL_MAX),
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LB)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cfg_wr),
        .i_phase (lut_phase),
        .o_dur   (dur),
        .o_peak  (peak)
    );

    assign dur_zero = (dur == '0);

    // Ramp end points of the current phase for the channel being worked on.
    // Held levels are written as ramps whose two ends are equal.
    always_comb begin
        white_sel = (r_state == S_WHITE_GO) || (r_state == S_WHITE_WAIT);
        ramp_a    = '0;
        ramp_b    = '0;
        unique case (r_phase)
            PH_DAWN: begin
                ramp_b = white_sel ? '0 : peak;
            end
            PH_SUNRISE: begin
                ramp_a = white_sel ? '0 : peak;
                ramp_b = LVL_FULL;
            end
            PH_NOON: begin
                ramp_a = LVL_FULL;
                ramp_b = LVL_FULL;
            end
            PH_SUNSET: begin
                ramp_a = LVL_FULL;
                ramp_b = white_sel ? '0 : peak;
            end
            PH_DUSK: begin
                ramp_a = white_sel ? '0 : peak;
            end
            default: begin
            end
        endcase
        ramp_up   = (ramp_b >= ramp_a);
        span      = ramp_up ? (ramp_b - ramp_a) : (ramp_a - ramp_b);
        e_clamped = (r_elapsed > dur) ? dur : r_elapsed;
        // A falling ramp truncates towards zero, so the quotient is taken
        // off the start value.
        if (dur_zero) begin
            level_new = ramp_a;
        end else if (ramp_up) begin
            level_new = ramp_a + div_quot;
        end else begin
            level_new = ramp_a - div_quot;
        end
    end

    assign div_start = (r_state == S_BLUE_GO) || (r_state == S_WHITE_GO);

    drs_ramp_div #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LB)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_elapsed (e_clamped),
        .i_span    (span),
        .i_dur     (dur),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    // Elapsed time saturates at the top of the counter.
    assign adv_sum = {1'b0, r_elapsed} + TW1'(r_adv);

    // Relay decisions: dawn closes blue from a low threshold, dusk opens it
    // below a higher one; the white relay follows the white fades.
    always_comb begin
        n_blue_sw  = r_blue_sw;
        n_white_sw = r_white_sw;
        unique case (r_phase)
            PH_DAWN: begin
                n_blue_sw = (32'(r_blue) >= RELAY_ON_LEVEL);
            end
            PH_SUNRISE, PH_SUNSET: begin
                n_white_sw = (32'(r_white) >= RELAY_ON_LEVEL);
            end
            PH_DUSK: begin
                n_blue_sw = (32'(r_blue) >= DUSK_OFF_LEVEL);
            end
            default: begin
            end
        endcase
    end

    assign tick_take = i_tick_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_DAWN;
            r_elapsed   <= '0;
            r_blue_sw   <= 1'b0;
            r_white_sw  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // The done state reloads the output register itself.
            if (r_out_valid && i_res_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (tick_take) begin
                        r_adv     <= i_tick.advance_ms;
                        r_restart <= i_tick.restart;
                        r_tries   <= '0;
                        if (i_tick.restart) begin
                            r_scan  <= PH_NIGHT;
                            r_state <= S_SCAN;
                        end else if (r_elapsed >= dur) begin
                            r_scan  <= r_phase;
                            r_state <= S_SCAN;
                        end else begin
                            r_state <= S_ADV;
                        end
                    end
                end
                S_SCAN: begin
                    // One candidate phase per cycle; passing dawn opens both
                    // relays as a new cycle begins.
                    if (scan_next == PH_DAWN) begin
                        r_blue_sw  <= 1'b0;
                        r_white_sw <= 1'b0;
                    end
                    if (!dur_zero) begin
                        r_phase   <= scan_next;
                        r_elapsed <= '0;
                        r_state   <= r_restart ? S_BLUE_GO : S_ADV;
                    end else if (r_tries == 3'(NPHASE - 1)) begin
                        // Every duration is zero: rest at dawn. The search
                        // has passed dawn, so both relays are already open.
                        r_phase   <= PH_DAWN;
                        r_elapsed <= '0;
                        r_state   <= r_restart ? S_BLUE_GO : S_ADV;
                    end else begin
                        r_scan  <= scan_next;
                        r_tries <= r_tries + 3'd1;
                    end
                end
                S_ADV: begin
                    r_elapsed <= adv_sum[TIME_BITS] ? '1 : adv_sum[TIME_BITS-1:0];
                    r_state   <= S_BLUE_GO;
                end
                S_BLUE_GO: begin
                    r_state <= S_BLUE_WAIT;
                end
                S_BLUE_WAIT: begin
                    if (div_done) begin
                        r_blue  <= level_new;
                        r_state <= S_WHITE_GO;
                    end
                end
                S_WHITE_GO: begin
                    r_state <= S_WHITE_WAIT;
                end
                S_WHITE_WAIT: begin
                    if (div_done) begin
                        r_white <= level_new;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_res_ready) begin
                        r_blue_sw            <= n_blue_sw;
                        r_white_sw           <= n_white_sw;
                        r_out.phase          <= r_phase;
                        r_out.blue_level     <= OUT_LVL_BITS'(r_blue);
                        r_out.white_level    <= OUT_LVL_BITS'(r_white);
                        r_out.blue_drive     <= OUT_LVL_BITS'(LVL_FULL - r_blue);
                        r_out.white_drive    <= OUT_LVL_BITS'(LVL_FULL - r_white);
                        r_out.blue_relay_on  <= n_blue_sw;
                        r_out.white_relay_on <= n_white_sw;
                        r_out_valid          <= 1'b1;
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_tick_ready = (r_state == S_IDLE);
    assign o_res_valid  = r_out_valid;
    assign o_res        = r_out;

`include "two_channel_daylight_ramp_sequencer_assert.svh"

    `DRS_ASSERT_NEXT(a_tick_busy, i_tick_valid && o_tick_ready, !o_tick_ready,
        "tick channel still ready after a transfer")
    `DRS_ASSERT_NOW(a_div_idle_start, div_start, !div_busy,
        "divider started while busy")
    `DRS_ASSERT_NOW(a_drive_sum, o_res_valid,
        OUT_LVL_BITS'(o_res.blue_level + o_res.blue_drive) == OUT_LVL_BITS'(LEVEL_MAX),
        "blue level and drive do not add up to full scale")
    `DRS_ASSERT_NOW(a_noon_full, o_res_valid && (o_res.phase == PH_NOON),
        (o_res.blue_level == OUT_LVL_BITS'(LEVEL_MAX)) &&
        (o_res.white_level == OUT_LVL_BITS'(LEVEL_MAX)),
        "noon result not at full scale")

endmodule

`default_nettype wire
